FILE: sv/lat_pkg.sv
// shared types and constants for the lag autocorrelation test unit
`default_nettype none
package lat_pkg;
	localparam int SMP_W   = 16;
	localparam int CNT_W   = 24;
	localparam int SUM_W   = 56;
	localparam int R_W     = 28;
	localparam int CSQ_W   = 32;
	localparam int Y_W     = CSQ_W + R_W;
	localparam int RAD_W   = 94;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int L_W     = SUM_W + 2;
	localparam int NUM_W   = L_W + 1;
	localparam int DEN_W   = 32;
	localparam int Z_W     = 25;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W  = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_LAG   = 2'd1;
	localparam logic [1:0] REG_CRIT  = 2'd2;

	typedef enum logic [2:0] {
		ST_RUN, ST_PREP, ST_SQ1, ST_MUL, ST_ITER, ST_FIN
	} lat_state_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_PREP, OP_SQRT, OP_MUL, OP_DIV, OP_FIN
	} lat_op_t;

	typedef struct packed {
		lat_op_t op;
		logic    sq_en;
		logic    accept;
	} lat_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic out_busy;
	} lat_stat_t;
endpackage
`default_nettype wire

FILE: sv/lat_ctrl.sv
// controller state machine sequencing accumulate, root, divide and finish
`default_nettype none
module lat_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tlast,
	input  wire lat_pkg::lat_stat_t stat,
	output logic                   s_tready,
	output lat_pkg::lat_cmd_t      cmd
);
	import lat_pkg::*;

	lat_state_t state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		s_tready   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.sq_en  = 1'b0;
		cmd.accept = 1'b0;
		case (state_q)
			ST_RUN: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && s_tlast) state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.op = OP_PREP;
				cnt_d  = '0;
				state_d = stat.n_zero ? ST_FIN : ST_SQ1;
			end
			ST_SQ1: begin
				cmd.op    = OP_SQRT;
				cmd.sq_en = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(SQ_STEPS - 1)) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.op  = OP_MUL;
				cnt_d   = '0;
				state_d = ST_ITER;
			end
			ST_ITER: begin
				cmd.op    = OP_DIV;
				cmd.sq_en = (cnt_q < STEP_W'(SQ_STEPS));
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.op = OP_FIN;
				if (!stat.out_busy) state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end
endmodule
`default_nettype wire

FILE: sv/lat_dp.sv
// datapath: pair accumulation, bit-serial root, restoring divide, result register
`default_nettype none
module lat_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lat_pkg::lat_cmd_t         cmd,
	input  wire logic [lat_pkg::SMP_W-1:0] sample,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [15:0]               cfg_data,
	input  wire logic                      m_tready,
	output logic                           m_tvalid,
	output logic [55:0]                    m_tdata,
	output logic [0:0]                     m_tuser,
	output lat_pkg::lat_stat_t             stat
);
	import lat_pkg::*;

	logic [15:0] start_q, lag_q, crit_q;
	logic [CNT_W-1:0] idx_q, pairs_q;
	logic [15:0] unk_q;
	logic [SMP_W-1:0] prev_q;
	logic have_q;
	logic [SUM_W-1:0] sum_q;

	logic [SUM_W-1:0] mag_q;
	logic neg_q;
	logic [R_W-1:0] r_q;
	logic [CSQ_W-1:0] csq_q;
	logic [L_W-1:0] l_q;
	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q, drem_q;

	logic [CNT_W-1:0] idx_nx;
	logic keep, fire;
	logic [SUM_W-1:0] quarter;
	logic [R_W-1:0] r_nx;
	logic [Y_W-1:0] y_nx;
	logic [REM_W+1:0] s_try;
	logic [REM_W-1:0] s_trial;
	logic s_ok;
	logic [DEN_W:0] d_try;
	logic d_ok;
	logic [Z_W-1:0] z_nx;
	logic pass;

	assign idx_nx = (idx_q != CNT_MAX) ? idx_q + 1'b1 : idx_q;
	assign keep   = have_q ? (unk_q == '0) : (idx_nx == CNT_W'(start_q));
	assign fire   = (cmd.op == OP_FIN) && !stat.out_busy;

	assign quarter = SUM_W'(pairs_q) << (2 * SMP_W - 2);
	assign r_nx    = R_W'(pairs_q) * R_W'(13) - R_W'(6);
	assign y_nx    = Y_W'(csq_q) * Y_W'(r_q);

	assign s_try   = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign s_trial = {root_q, 2'b01};
	assign s_ok    = s_try >= (REM_W+2)'(s_trial);

	assign d_try = {drem_q, num_q[NUM_W-1]};
	assign d_ok  = d_try >= (DEN_W+1)'(den_q);

	assign stat.n_zero   = (pairs_q == '0);
	assign stat.out_busy = m_tvalid && !m_tready;

	// saturate quotient and apply sign
	always_comb begin
		if (neg_q) begin
			if (num_q > NUM_W'(24'hFFFFFF) + 1'b1) z_nx = {1'b1, 24'd0};
			else z_nx = Z_W'(-num_q);
		end else begin
			if (num_q > NUM_W'(24'hFFFFFF)) z_nx = {1'b0, 24'hFFFFFF};
			else z_nx = Z_W'(num_q);
		end
	end
	assign pass = (l_q <= L_W'(root_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= 16'd3;
			lag_q    <= 16'd5;
			crit_q   <= 16'd16056;
			idx_q    <= '0;
			unk_q    <= '0;
			prev_q   <= '0;
			have_q   <= 1'b0;
			sum_q    <= '0;
			pairs_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START: start_q <= cfg_data;
					REG_LAG:   lag_q   <= cfg_data;
					REG_CRIT:  crit_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				idx_q <= idx_nx;
				if (keep) begin
					if (have_q && pairs_q != CNT_MAX) begin
						sum_q   <= sum_q + SUM_W'(32'(prev_q) * 32'(sample));
						pairs_q <= pairs_q + 1'b1;
					end
					prev_q <= sample;
					have_q <= 1'b1;
					unk_q  <= lag_q - 1'b1;
				end else if (have_q) begin
					unk_q <= unk_q - 1'b1;
				end
			end
			if (fire) begin
				m_tvalid <= 1'b1;
				idx_q    <= '0;
				unk_q    <= '0;
				prev_q   <= '0;
				have_q   <= 1'b0;
				sum_q    <= '0;
				pairs_q  <= '0;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_PREP: begin
				neg_q  <= sum_q < quarter;
				mag_q  <= (sum_q < quarter) ? quarter - sum_q : sum_q - quarter;
				r_q    <= r_nx;
				csq_q  <= CSQ_W'(crit_q) * CSQ_W'(crit_q);
				rad_q  <= RAD_W'(r_nx) << 32;
				srem_q <= '0;
				root_q <= '0;
			end
			OP_MUL: begin
				num_q  <= NUM_W'(l_q) + NUM_W'({root_q, 1'b0});
				den_q  <= DEN_W'({root_q, 2'b00});
				drem_q <= '0;
				rad_q  <= RAD_W'(y_nx) << 34;
				srem_q <= '0;
				root_q <= '0;
			end
			OP_FIN: begin
				if (fire) begin
					if (stat.n_zero) begin
						m_tdata    <= '0;
						m_tuser[0] <= 1'b1;
					end else begin
						m_tdata    <= {6'd0, pairs_q, pass, z_nx};
						m_tuser[0] <= 1'b0;
					end
				end
			end
			default: ;
		endcase
		if (cmd.op == OP_SQRT) l_q <= L_W'(mag_q) + L_W'({mag_q, 1'b0});
		if (cmd.sq_en) begin
			rad_q <= rad_q << 2;
			if (s_ok) begin
				srem_q <= REM_W'(s_try - (REM_W+2)'(s_trial));
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= REM_W'(s_try);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.op == OP_DIV) begin
			drem_q <= d_ok ? DEN_W'(d_try - (DEN_W+1)'(den_q)) : DEN_W'(d_try);
			num_q  <= {num_q[NUM_W-2:0], d_ok};
		end
	end
endmodule
`default_nettype wire

FILE: sv/lag_autocorrelation_test_unit.sv
// top level of the lag autocorrelation independence test unit
//
// channel   dir  handshake            contents
// s_*       in   s_tvalid/s_tready    tdata: sample[15:0]; tlast: end of sequence
// m_*       out  m_tvalid/m_tready    tdata: z_score, independent, pair_count; tuser: status
// cfg_*     in   cfg_we               index 0 start_position, 1 lag, 2 critical_z
//
// samples are taken one word per cycle; the product and running sum update in that cycle
// after the word marked last: a prep step, 47 root steps, a multiply step, 59 divide
// steps (second root runs alongside), then a finish step; with no pairs, prep goes to finish
// s_tready is low from the last word until finish; finish waits for the result register
// arst_n clears test state and restores register defaults; no clearing pass
`default_nettype none
module lag_autocorrelation_test_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // sample[15:0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,  // z_score[24:0], independent[25], pair_count[49:26]
	output logic [0:0]       m_tuser,  // status[0]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import lat_pkg::*;

	lat_cmd_t  cmd;
	lat_stat_t stat;

	// sequencer for accumulate and closing arithmetic
	lat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	// accumulator, iterative root and divider, result register
	lat_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.stat      (stat)
	);

	// no new samples while the closing arithmetic runs
	a_hold_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("sample accepted right after last word");

	// an insufficient result carries no statistic
	a_insuff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[49:0] == '0)
		else $error("insufficient result with nonzero fields");

	// a valid result always reports at least one pair
	a_pairs_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[49:26] != '0)
		else $error("valid result with zero pairs");
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// self-checking testbench for the lag autocorrelation independence test unit
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lat_pkg::*;

	// one closing result of a test run
	typedef struct packed {
		logic [24:0] z_score;
		logic        independent;
		logic [23:0] pair_count;
		logic        status;
	} test_result_t;

	// one row of the directed table; status is typed in only where noted
	typedef struct packed {
		logic [15:0] sample;
		logic        last;
		logic        typed;
		logic        status;
	} stim_row_t;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES  = 400;
	localparam int DIR_ROWS     = 20;
	localparam int WORD_TARGET  = 500;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // sample[15:0]
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;  // z_score[24:0], independent[25], pair_count[49:26]
	logic [0:0]  m_tuser;  // status[0]
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	lag_autocorrelation_test_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the block's registers and test state
	logic [15:0] start_pos, lag_dist, crit_bound;
	logic [23:0] seen_count, pair_total;
	logic [15:0] keep_countdown, last_kept;
	logic        kept_any;
	logic [55:0] product_acc;

	test_result_t pending_results[$];
	int errors       = 0;
	int words_sent   = 0;
	int results_seen = 0;
	int cycles       = 0;
	bit idle_on      = 1'b1;  // random gaps on both sides
	bit hold_req     = 1'b0;  // ask the receiver for one long stall

	stim_row_t dir_rows[DIR_ROWS];

	// bitwise integer square root, floor
	function automatic logic [63:0] int_root(input logic [63:0] v);
		logic [63:0] r, b, x;
		r = '0;
		x = v;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// closing statistic from the pair count and product sum
	function automatic test_result_t close_test(input logic [23:0] n, input logic [55:0] acc);
		test_result_t res;
		logic [63:0]  quarter, mag, rad, root, lin, quo;
		logic [127:0] lhs, rhs;
		logic         neg;
		res = '0;
		if (n == 0) begin
			res.status = 1'b1;
			return res;
		end
		quarter = 64'(n) << 30;
		neg     = 64'(acc) < quarter;
		mag     = neg ? quarter - 64'(acc) : 64'(acc) - quarter;
		rad     = 64'd13 * 64'(n) - 64'd6;
		root    = int_root(rad << 32);
		lin     = 64'd3 * mag;
		quo     = (lin + 64'd2 * root) / (64'd4 * root);
		if (neg) begin
			if (quo > 64'd16777216)
				quo = 64'd16777216;
			res.z_score = 25'(64'd0 - quo);
		end else begin
			if (quo > 64'd16777215)
				quo = 64'd16777215;
			res.z_score = 25'(quo);
		end
		// exact acceptance: (3|D|)^2 <= crit^2 * R * 2^34
		lhs = 128'(lin) * 128'(lin);
		rhs = (128'(crit_bound) * 128'(crit_bound) * 128'(rad)) << 34;
		res.independent = (lhs <= rhs);
		res.pair_count  = n;
		return res;
	endfunction

	function automatic void clear_state();
		seen_count     = '0;
		keep_countdown = '0;
		last_kept      = '0;
		kept_any       = 1'b0;
		product_acc    = '0;
		pair_total     = '0;
	endfunction

	// advance the mirrored state by one accepted word; returns 1 on a closing word
	function automatic bit predict_word(input logic [15:0] smp, input logic lst,
			output test_result_t res);
		bit keep;
		if (seen_count != CNT_MAX)
			seen_count = seen_count + 24'd1;
		if (!kept_any) begin
			keep = (seen_count == 24'(start_pos));
		end else if (keep_countdown == 0) begin
			keep = 1'b1;
		end else begin
			keep = 1'b0;
			keep_countdown = keep_countdown - 16'd1;
		end
		if (keep) begin
			// saturated pair count freezes the sum
			if (kept_any && pair_total != CNT_MAX) begin
				product_acc = product_acc + 56'(32'(last_kept) * 32'(smp));
				pair_total  = pair_total + 24'd1;
			end
			last_kept      = smp;
			kept_any       = 1'b1;
			keep_countdown = lag_dist - 16'd1;
		end
		res = '0;
		if (!lst)
			return 1'b0;
		res = close_test(pair_total, product_acc);
		clear_state();
		return 1'b1;
	endfunction

	// offer one word with optional gap before it, then wait for acceptance
	task automatic send_word(input logic [15:0] smp, input logic lst,
			input bit typed, input logic typed_status);
		test_result_t res;
		bit closes;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		closes = predict_word(smp, lst, res);
		if (closes) begin
			if (typed) begin
				res = '0;
				res.status = typed_status;
			end
			pending_results = {pending_results, res};
		end
	endtask

	// register write, only with the block idle
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_START: start_pos  = val;
			REG_LAG:   lag_dist   = val;
			REG_CRIT:  crit_bound = val;
			default: ;  // unused index, ignored
		endcase
	endtask

	task automatic write_config(input logic [15:0] sp, input logic [15:0] lg,
			input logic [15:0] cz);
		write_reg(REG_START, sp);
		write_reg(REG_LAG, lg);
		write_reg(REG_CRIT, cz);
	endtask

	// one test run of random length; some runs are flat at an extreme
	task automatic send_run();
		int len, kind;
		logic [15:0] smp;
		len  = $urandom_range(1, 40);
		kind = $urandom_range(0, 9);
		for (int i = 0; i < len; i++) begin
			case (kind)
				0:       smp = 16'h0000;
				1:       smp = 16'hFFFF;
				2:       smp = 16'h8000 ^ 16'($urandom_range(0, 3));
				default: smp = 16'($urandom);
			endcase
			if (words_sent == 150)
				hold_req = 1'b1;
			if (words_sent > 420)
				idle_on = 1'b0;
			send_word(smp, (i == len - 1), 1'b0, 1'b0);
		end
	endtask

	// checker and receiver-side flow control
	initial begin : receiver
		int stall_left;
		test_result_t want;
		bit held;
		stall_left = 0;
		held = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[24:0] !== want.z_score) begin
						$error("z_score expected %0h actual %0h", want.z_score, m_tdata[24:0]);
						errors++;
					end
					if (m_tdata[25] !== want.independent) begin
						$error("independent expected %0b actual %0b",
							want.independent, m_tdata[25]);
						errors++;
					end
					if (m_tdata[49:26] !== want.pair_count) begin
						$error("pair_count expected %0d actual %0d",
							want.pair_count, m_tdata[49:26]);
						errors++;
					end
					if (m_tuser[0] !== want.status) begin
						$error("status expected %0b actual %0b", want.status, m_tuser[0]);
						errors++;
					end
				end
			end
			if (hold_req && !held) begin
				// long stall so the result register fills and the input backs up
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : sender
		int wait_cnt;
		// directed table, run with every sample kept
		dir_rows = '{
			'{16'h1234, 1'b1, 1'b1, 1'b1},  // lone closing word, no pairs
			'{16'hFFFF, 1'b0, 1'b0, 1'b0}, '{16'hFFFF, 1'b1, 1'b0, 1'b0},
			'{16'h0000, 1'b0, 1'b0, 1'b0}, '{16'h0000, 1'b0, 1'b0, 1'b0},
			'{16'h0000, 1'b1, 1'b0, 1'b0},  // all zero, negative z
			'{16'h8000, 1'b0, 1'b0, 1'b0}, '{16'h8000, 1'b1, 1'b0, 1'b0},  // exactly a quarter
			'{16'h0000, 1'b0, 1'b0, 1'b0}, '{16'hFFFF, 1'b0, 1'b0, 1'b0},
			'{16'h0000, 1'b0, 1'b0, 1'b0}, '{16'hFFFF, 1'b0, 1'b0, 1'b0},
			'{16'h0000, 1'b1, 1'b0, 1'b0},
			'{16'hFFFF, 1'b0, 1'b0, 1'b0}, '{16'hFFFF, 1'b0, 1'b0, 1'b0},
			'{16'hFFFF, 1'b0, 1'b0, 1'b0}, '{16'hFFFF, 1'b1, 1'b0, 1'b0},  // top of range
			'{16'h0001, 1'b1, 1'b1, 1'b1},  // again no pairs
			'{16'hAAAA, 1'b0, 1'b0, 1'b0}, '{16'h5555, 1'b1, 1'b0, 1'b0}
		};
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		start_pos  = 16'd3;
		lag_dist   = 16'd5;
		crit_bound = 16'd16056;
		clear_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a couple of runs on the reset defaults
		send_run();
		send_run();
		write_reg(REG_UNUSED, 16'hFFFF);  // unused index must change nothing
		send_run();

		write_config(16'd1, 16'd1, 16'd16056);
		for (int i = 0; i < DIR_ROWS; i++)
			send_word(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].typed,
				dir_rows[i].status);

		// random phases over a spread of settings, extremes among them
		for (int ph = 0; words_sent < WORD_TARGET; ph++) begin
			case (ph % 8)
				0: write_config(16'd1, 16'd1, 16'd0);
				1: write_config(16'd2, 16'd2, 16'hFFFF);
				2: write_config(16'hFFFF, 16'hFFFF, 16'd16056);  // start never reached
				3: write_config(16'd1, 16'd0, 16'd8000);  // lag wraps to 65536
				4: write_config(16'd0, 16'd3, 16'd20000);  // position zero never kept
				5: write_config(16'd3, 16'd5, 16'd16056);
				default: write_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
					16'($urandom));
			endcase
			repeat ($urandom_range(3, 8))
				if (words_sent < WORD_TARGET)
					send_run();
		end
		s_tvalid <= 1'b0;

		wait_cnt = 0;
		while (pending_results.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
sv/lat_pkg.sv
sv/lat_ctrl.sv
sv/lat_dp.sv
sv/lag_autocorrelation_test_unit.sv
bench/testbench.sv
